// ----- src/upsd_pkg.sv -----
// Shared types, constants and helpers for the UPS patch stream decoder.
package upsd_pkg;

  localparam int OFFSET_WIDTH_DEF = 32;
  localparam int BYTE_W           = 8;
  localparam int OUT_OFS_W        = 32;
  localparam int POS_W            = 32;
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_ADDR_W       = 3;
  localparam int CHECKSUM_BYTES   = 12;
  localparam int VARINT_STEP      = 7;
  localparam int MAGIC_LEN        = 4;

  localparam logic [BYTE_W-1:0] VARINT_DATA_MASK = 8'h7f;
  localparam logic [BYTE_W-1:0] VARINT_LAST_MASK = 8'h80;

  // register index = word address
  localparam logic REG_PATCH_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    ST_RUNNING   = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_DONE      = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    logic                 write_valid;
    logic [OUT_OFS_W-1:0] write_offset;
    logic [BYTE_W-1:0]    xor_mask;
    status_t              status;
  } res_t;

  // "UPS1"
  function automatic logic [BYTE_W-1:0] magic_byte(input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      2'd0:    b = 8'h55;
      2'd1:    b = 8'h50;
      2'd2:    b = 8'h53;
      default: b = 8'h31;
    endcase
    return b;
  endfunction

endpackage

// ----- src/upsd_regs.sv -----
// APB configuration register: patch length and the derived hunk region end.
module upsd_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [upsd_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [upsd_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [upsd_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [upsd_pkg::POS_W-1:0]          hunk_end
);

  logic [upsd_pkg::CFG_DATA_W-1:0] patch_length_r;
  logic [upsd_pkg::POS_W-1:0]      hunk_end_r;
  logic                            reg_idx;
  logic                            wr_en;

  assign reg_idx = paddr[upsd_pkg::CFG_ADDR_W-1];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready &&
                   (reg_idx == upsd_pkg::REG_PATCH_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      patch_length_r <= '0;
      hunk_end_r     <= '0;
    end else if (wr_en) begin
      patch_length_r <= pwdata;
      // short patch: region end clamps at zero
      if (pwdata >= upsd_pkg::CFG_DATA_W'(upsd_pkg::CHECKSUM_BYTES)) begin
        hunk_end_r <= pwdata - upsd_pkg::CFG_DATA_W'(upsd_pkg::CHECKSUM_BYTES);
      end else begin
        hunk_end_r <= '0;
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      upsd_pkg::REG_PATCH_LENGTH: prdata = patch_length_r;
      default:                    prdata = '0;
    endcase
  end

  assign hunk_end = hunk_end_r;

endmodule

// ----- src/upsd_core.sv -----
// Decoder state and the per-byte step: magic, size varints, skip varints, XOR runs.
module upsd_core #(
  parameter int OFFSET_WIDTH = upsd_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_go,
  input  logic [upsd_pkg::BYTE_W-1:0]   step_byte,
  input  logic [upsd_pkg::POS_W-1:0]    hunk_end,
  output upsd_pkg::res_t                res
);

  localparam int W   = OFFSET_WIDTH;
  localparam int SHW = $clog2(W);

  typedef enum logic [2:0] {
    PH_MAGIC, PH_SRC, PH_DST, PH_SKIP, PH_XOR, PH_DONE, PH_BAD, PH_OVF
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [upsd_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [W-1:0]                 accum_r, accum_nxt;
  logic [SHW-1:0]               shift_r, shift_nxt;
  logic [W-1:0]                 offset_r, offset_nxt;

  logic [6:0]                   digit;
  logic                         last_b;
  logic [W+6:0]                 term_wide;
  logic                         digit_ovf;
  logic [W-1:0]                 term;
  logic [SHW:0]                 nshift;
  logic                         shift_ovf;
  logic [W-1:0]                 next_bit;
  logic [W+1:0]                 sum_more;
  logic [W+1:0]                 sum_last;
  logic [63:0]                  offset_ext;

  assign digit     = 7'(step_byte & upsd_pkg::VARINT_DATA_MASK);
  assign last_b    = (step_byte & upsd_pkg::VARINT_LAST_MASK) != '0;
  assign term_wide = (W+7)'(digit) << shift_r;
  assign digit_ovf = |term_wide[W+6:W];
  assign term      = term_wide[W-1:0];
  assign nshift    = (SHW+1)'(shift_r) + (SHW+1)'(upsd_pkg::VARINT_STEP);
  assign shift_ovf = 32'(nshift) >= 32'(W);
  assign next_bit  = W'(1) << nshift;
  // term and the continuation weight occupy disjoint bits, so one add covers both
  assign sum_more  = (W+2)'(accum_r) + (W+2)'(term | next_bit);
  assign sum_last  = (W+2)'(offset_r) + (W+2)'(accum_r) + (W+2)'(term);
  assign offset_ext = 64'(offset_r);

  function automatic upsd_pkg::status_t phase_status(input phase_t ph);
    upsd_pkg::status_t s;
    unique case (ph)
      PH_BAD:  s = upsd_pkg::ST_BAD_MAGIC;
      PH_DONE: s = upsd_pkg::ST_DONE;
      PH_OVF:  s = upsd_pkg::ST_OVERFLOW;
      default: s = upsd_pkg::ST_RUNNING;
    endcase
    return s;
  endfunction

  always_comb begin
    phase_nxt        = phase_r;
    pos_nxt          = pos_r;
    accum_nxt        = accum_r;
    shift_nxt        = shift_r;
    offset_nxt       = offset_r;
    res.write_valid  = 1'b0;
    res.write_offset = '0;
    res.xor_mask     = '0;

    if (phase_r == PH_DONE || phase_r == PH_BAD || phase_r == PH_OVF) begin
      // terminal: byte ignored
    end else if (phase_r == PH_SKIP && shift_r == '0 && accum_r == '0 &&
                 pos_r >= hunk_end) begin
      phase_nxt = PH_DONE;
    end else begin
      if (pos_r != '1) pos_nxt = pos_r + 1'b1;
      unique case (phase_r)
        PH_MAGIC: begin
          if (pos_r > upsd_pkg::POS_W'(upsd_pkg::MAGIC_LEN - 1) ||
              step_byte != upsd_pkg::magic_byte(pos_r[1:0])) begin
            phase_nxt = PH_BAD;
          end else if (pos_r == upsd_pkg::POS_W'(upsd_pkg::MAGIC_LEN - 1)) begin
            phase_nxt = PH_SRC;
          end
        end
        PH_SRC: begin
          if (last_b) phase_nxt = PH_DST;
        end
        PH_DST: begin
          if (last_b) phase_nxt = PH_SKIP;
        end
        PH_SKIP: begin
          if (digit_ovf) begin
            phase_nxt = PH_OVF;
          end else if (last_b) begin
            if (|sum_last[W+1:W]) begin
              phase_nxt = PH_OVF;
            end else begin
              offset_nxt = sum_last[W-1:0];
              phase_nxt  = PH_XOR;
            end
            accum_nxt = '0;
            shift_nxt = '0;
          end else if (shift_ovf || (|sum_more[W+1:W])) begin
            phase_nxt = PH_OVF;
          end else begin
            accum_nxt = sum_more[W-1:0];
            shift_nxt = nshift[SHW-1:0];
          end
        end
        PH_XOR: begin
          if (step_byte != '0) begin
            res.write_valid  = 1'b1;
            res.write_offset = offset_ext[upsd_pkg::OUT_OFS_W-1:0];
            res.xor_mask     = step_byte;
          end else begin
            phase_nxt = PH_SKIP;
          end
          if (offset_r == '1) phase_nxt = PH_OVF;
          else                offset_nxt = offset_r + 1'b1;
        end
        default: ;
      endcase
    end
    res.status = phase_status(phase_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAGIC;
      pos_r    <= '0;
      accum_r  <= '0;
      shift_r  <= '0;
      offset_r <= '0;
    end else if (step_go) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      accum_r  <= accum_nxt;
      shift_r  <= shift_nxt;
      offset_r <= offset_nxt;
    end
  end

  a_write_only_in_xor: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && res.write_valid |-> phase_r == PH_XOR)
    else $error("write produced outside an XOR run");

  a_terminal_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE || phase_r == PH_BAD || phase_r == PH_OVF) |=>
    phase_r == $past(phase_r))
    else $error("decoder left a terminal phase");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(shift_r) < 32'(W))
    else $error("varint shift beyond offset width");

  // an overflow mid-varint leaves the partial value behind
  a_varint_clear_outside_skip: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_SKIP && phase_r != PH_OVF |-> accum_r == '0 && shift_r == '0)
    else $error("varint accumulator not cleared outside skip phase");

endmodule

// ----- src/ups_patch_stream_decoder.sv -----
// Top level of the UPS patch stream decoder: input register, decoder core, result register.
// Takes one patch byte per cycle and returns one result per byte, sustained at one
// transaction per clock while out_ready stays high; a byte's result passes through the input
// register, then the decoder step into the result register. The rate is set by the
// combinational update of the varint accumulator and image offset, which feeds back into
// itself for every byte. While a result is stalled one more byte can still be taken into the
// input register; after that in_ready stays low until the result is taken. No clearing pass
// after reset. patch_length lies at byte address 0 and is to be written only while the
// decoder is idle, which the user must ensure; the block itself does not enforce it. Status
// is sticky once it reports bad magic, end of hunks or offset overflow, until reset.
module ups_patch_stream_decoder #(
  parameter int OFFSET_WIDTH = upsd_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [upsd_pkg::BYTE_W-1:0]         in_patch_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_write_valid,
  output logic [upsd_pkg::OUT_OFS_W-1:0]      out_write_offset,
  output logic [upsd_pkg::BYTE_W-1:0]         out_xor_mask,
  output logic [1:0]                          out_status,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [upsd_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [upsd_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [upsd_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  logic                        in_v_r;
  logic [upsd_pkg::BYTE_W-1:0] in_byte_r;
  logic                        out_v_r;
  upsd_pkg::res_t              out_r;
  upsd_pkg::res_t              res;
  logic [upsd_pkg::POS_W-1:0]  hunk_end;
  logic                        advance;

  upsd_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .hunk_end (hunk_end)
  );

  upsd_core #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_go   (advance),
    .step_byte (in_byte_r),
    .hunk_end  (hunk_end),
    .res       (res)
  );

  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte_r <= in_patch_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_r <= res;
  end

  assign out_valid        = out_v_r;
  assign out_write_valid  = out_r.write_valid;
  assign out_write_offset = out_r.write_offset;
  assign out_xor_mask     = out_r.xor_mask;
  assign out_status       = out_r.status;

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ready |=> out_v_r && $stable(out_r))
    else $error("result changed while stalled");

  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && out_v_r && !out_ready |-> !in_ready)
    else $error("input accepted with both stages full");

endmodule

// ----- dv/ups_patch_stream_decoder_test.sv -----
// Self-checking testbench for the UPS patch stream decoder: byte stream stimulus and result checks.
`timescale 1ns / 1ps

module ups_patch_stream_decoder_test;

  localparam int          CYCLE    = 20;
  localparam int          OFS_BITS = upsd_pkg::OFFSET_WIDTH_DEF;
  localparam logic [63:0] OFS_MAX  = (64'd1 << OFS_BITS) - 64'd1;
  localparam logic [31:0] UPS_TAG  = 32'h5550_5331;
  localparam logic [upsd_pkg::CFG_ADDR_W-1:0] PATCH_LENGTH_ADDR =
    upsd_pkg::CFG_ADDR_W'(upsd_pkg::REG_PATCH_LENGTH) << 2;

  typedef enum logic [2:0] {
    DEC_MAGIC, DEC_SRC, DEC_DST, DEC_SKIP, DEC_XOR, DEC_DONE, DEC_BAD, DEC_OVF
  } dec_phase_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [upsd_pkg::BYTE_W-1:0]     in_patch_byte;
  logic                            out_valid;
  logic                            out_ready;
  logic                            out_write_valid;
  logic [upsd_pkg::OUT_OFS_W-1:0]  out_write_offset;
  logic [upsd_pkg::BYTE_W-1:0]     out_xor_mask;
  logic [1:0]                      out_status;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [upsd_pkg::CFG_ADDR_W-1:0] paddr;
  logic [upsd_pkg::CFG_DATA_W-1:0] pwdata;
  logic [upsd_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  ups_patch_stream_decoder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_patch_byte    (in_patch_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_valid  (out_write_valid),
    .out_write_offset (out_write_offset),
    .out_xor_mask     (out_xor_mask),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // decoder state as predicted
  logic [31:0] cfg_patch_len;
  dec_phase_t  dec_phase;
  logic [31:0] dec_pos;
  logic [63:0] skip_acc;
  int          skip_shift;
  logic [63:0] img_ofs;

  logic [upsd_pkg::BYTE_W-1:0] patch_bytes_q[$];
  upsd_pkg::res_t              decoded_due[$];

  int unsigned n_bytes_sent;
  int unsigned n_bytes_taken;
  int unsigned n_results;
  int unsigned n_errors;
  int          send_gap, send_burst, recv_gap, recv_burst;
  int          long_hold;
  bit          long_hold_done;

  // generator view of the stream
  int unsigned gen_pos;
  logic [63:0] gen_ofs;

  initial begin
    clk = 1'b0;
    forever #(CYCLE / 2) clk = ~clk;
  end

  initial begin
    #(CYCLE * 1000000);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic upsd_pkg::res_t ups_decode_step(input logic [upsd_pkg::BYTE_W-1:0] b);
    upsd_pkg::res_t r;
    logic [31:0]    p;
    logic [31:0]    hunk_end;
    logic [63:0]    digit;
    logic [63:0]    term;
    logic           last;
    logic           ok;
    r        = '0;
    p        = dec_pos;
    hunk_end = (cfg_patch_len >= upsd_pkg::CHECKSUM_BYTES) ?
               cfg_patch_len - upsd_pkg::CHECKSUM_BYTES : 32'd0;
    if (dec_phase == DEC_SKIP && skip_shift == 0 && skip_acc == 0 && p >= hunk_end)
      dec_phase = DEC_DONE;
    else if (!(dec_phase inside {DEC_DONE, DEC_BAD, DEC_OVF})) begin
      if (dec_pos != 32'hffff_ffff) dec_pos = dec_pos + 32'd1;
      case (dec_phase)
        DEC_MAGIC: begin
          if (p > upsd_pkg::MAGIC_LEN - 1 || b != UPS_TAG[8 * (3 - p[1:0]) +: 8])
            dec_phase = DEC_BAD;
          else if (p == upsd_pkg::MAGIC_LEN - 1) dec_phase = DEC_SRC;
        end
        DEC_SRC: begin
          if ((b & upsd_pkg::VARINT_LAST_MASK) != 0) dec_phase = DEC_DST;
        end
        DEC_DST: begin
          if ((b & upsd_pkg::VARINT_LAST_MASK) != 0) dec_phase = DEC_SKIP;
        end
        DEC_SKIP: begin
          last  = (b & upsd_pkg::VARINT_LAST_MASK) != 0;
          digit = 64'(b & upsd_pkg::VARINT_DATA_MASK);
          ok    = 1'b1;
          if (digit > (OFS_MAX >> skip_shift)) ok = 1'b0;
          else begin
            term = digit << skip_shift;
            if (OFS_MAX - skip_acc < term) ok = 1'b0;
            else begin
              skip_acc = skip_acc + term;
              if (!last) begin
                if (skip_shift + upsd_pkg::VARINT_STEP >= OFS_BITS) ok = 1'b0;
                else begin
                  skip_shift = skip_shift + upsd_pkg::VARINT_STEP;
                  term       = 64'd1 << skip_shift;
                  if (OFS_MAX - skip_acc < term) ok = 1'b0;
                  else skip_acc = skip_acc + term;
                end
              end
            end
          end
          if (!ok) dec_phase = DEC_OVF;
          else if (last) begin
            if (OFS_MAX - img_ofs < skip_acc) dec_phase = DEC_OVF;
            else begin
              img_ofs   = img_ofs + skip_acc;
              dec_phase = DEC_XOR;
            end
            skip_acc   = '0;
            skip_shift = 0;
          end
        end
        default: begin
          if (b != 0) begin
            r.write_valid  = 1'b1;
            r.write_offset = img_ofs[upsd_pkg::OUT_OFS_W-1:0];
            r.xor_mask     = b;
          end else begin
            dec_phase = DEC_SKIP;
          end
          // a write at the top offset is still reported
          if (img_ofs >= OFS_MAX) dec_phase = DEC_OVF;
          else img_ofs = img_ofs + 64'd1;
        end
      endcase
    end
    case (dec_phase)
      DEC_BAD:  r.status = upsd_pkg::ST_BAD_MAGIC;
      DEC_DONE: r.status = upsd_pkg::ST_DONE;
      DEC_OVF:  r.status = upsd_pkg::ST_OVERFLOW;
      default:  r.status = upsd_pkg::ST_RUNNING;
    endcase
    return r;
  endfunction

  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 3) begin
      burst = $urandom_range(40, 150);
      return 0;
    end
    if (r < 120) return 0;
    if (r < 180) return $urandom_range(1, 3);
    if (r < 196) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // input side: prediction at acceptance
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      decoded_due.push_back(ups_decode_step(in_patch_byte));
      n_bytes_taken++;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || n_bytes_taken == n_bytes_sent)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (patch_bytes_q.size() > 0) begin
        in_patch_byte <= patch_bytes_q.pop_front();
        in_valid      <= 1'b1;
        n_bytes_sent++;
        send_gap = pick_gap(send_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && n_results >= 600 && patch_bytes_q.size() >= 100) begin
      // long back-pressure while the sender keeps offering
      long_hold_done = 1'b1;
      long_hold      = 400;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      recv_gap = pick_gap(recv_burst);
    end
  end

  always @(posedge clk) begin
    upsd_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (decoded_due.size() == 0) begin
        $error("result transaction with nothing expected");
        n_errors++;
      end else begin
        want = decoded_due.pop_front();
        if (out_write_valid !== want.write_valid) begin
          $error("write_valid: expected %0d, got %0d", want.write_valid, out_write_valid);
          n_errors++;
        end
        if (out_write_offset !== want.write_offset) begin
          $error("write_offset: expected %h, got %h", want.write_offset, out_write_offset);
          n_errors++;
        end
        if (out_xor_mask !== want.xor_mask) begin
          $error("xor_mask: expected %h, got %h", want.xor_mask, out_xor_mask);
          n_errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          n_errors++;
        end
      end
    end
  end

  task automatic apb_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PATCH_LENGTH_ADDR;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_patch_length(input logic [31:0] len);
    logic [31:0] rd;
    apb_xfer(1'b1, len, rd);
    cfg_patch_len = len;
    apb_xfer(1'b0, '0, rd);
    if (rd !== len) begin
      $error("patch_length readback: expected %h, got %h", len, rd);
      n_errors++;
    end
  endtask

  task automatic wait_drained();
    while (patch_bytes_q.size() != 0 || in_valid || decoded_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_byte(input logic [upsd_pkg::BYTE_W-1:0] b);
    patch_bytes_q.push_back(b);
    gen_pos++;
  endtask

  task automatic push_skip(input logic [63:0] skip);
    logic [63:0] v;
    logic [6:0]  x;
    v = skip;
    while (1) begin
      x = v[6:0];
      v = v >> upsd_pkg::VARINT_STEP;
      if (v == 0) begin
        push_byte({1'b1, x});
        break;
      end
      push_byte({1'b0, x});
      v = v - 64'd1;
    end
    gen_ofs = gen_ofs + skip;
  endtask

  task automatic push_xor(input logic [upsd_pkg::BYTE_W-1:0] b);
    push_byte(b);
    gen_ofs = gen_ofs + 64'd1;
  endtask

  task automatic push_random_hunk();
    int          r;
    int          n;
    logic [63:0] skip;
    r = $urandom_range(0, 99);
    if (r < 45) skip = $urandom_range(0, 127);
    else if (r < 80) skip = $urandom_range(128, 16511);
    else if (r < 96) skip = $urandom_range(16512, 2113663);
    else if (gen_ofs < 64'h4000_0000) skip = $urandom_range(2113664, 270549119);
    else skip = $urandom_range(0, 127);
    push_skip(skip);
    r = $urandom_range(0, 99);
    if (r < 10) n = 0;
    else if (r < 85) n = $urandom_range(1, 8);
    else n = $urandom_range(9, 40);
    repeat (n) push_xor(8'($urandom_range(1, 255)));
    push_xor('0);
  endtask

  initial begin
    int unsigned next_cfg;
    int unsigned stop_pos;
    int          n_cfg;
    int          final_mode;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_patch_byte = '0;
    out_ready     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    cfg_patch_len = '0;
    dec_phase     = DEC_MAGIC;
    dec_pos       = '0;
    skip_acc      = '0;
    skip_shift    = 0;
    img_ofs       = '0;
    n_bytes_sent  = 0;
    n_bytes_taken = 0;
    n_results     = 0;
    n_errors      = 0;
    send_gap      = 0;
    send_burst    = 0;
    recv_gap      = 0;
    recv_burst    = 0;
    long_hold     = 0;
    long_hold_done = 1'b0;
    gen_pos       = 0;
    gen_ofs       = '0;
    n_cfg         = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // header under a zero length: the end test only bites at a hunk start
    set_patch_length(32'd0);
    for (int i = 0; i < upsd_pkg::MAGIC_LEN; i++) push_byte(UPS_TAG[8 * (3 - i) +: 8]);
    push_byte(8'h00);
    push_byte(8'h7f);
    push_byte(8'h80);
    wait_drained();
    set_patch_length(32'hffff_ffff);
    push_byte(8'hff);
    push_skip(64'd0);
    push_xor(8'hff);
    push_xor(8'h01);
    push_xor(8'h80);
    push_xor(8'h55);
    push_xor(8'h00);
    push_skip(64'd128);
    push_xor(8'h7f);
    push_xor(8'h00);
    push_skip(64'd16511);
    push_xor(8'h00);
    push_skip(64'd127);
    push_xor(8'h00);

    next_cfg = 450;
    while (gen_pos < 1800) begin
      push_random_hunk();
      if (gen_pos >= next_cfg) begin
        wait_drained();
        n_cfg++;
        if (n_cfg % 2 == 0) set_patch_length(32'hffff_ffff);
        else set_patch_length(gen_pos + upsd_pkg::CHECKSUM_BYTES + $urandom_range(3000, 100000));
        next_cfg = next_cfg + 450;
      end
    end

    // status is sticky until reset, so the run closes on one terminal case
    final_mode = $urandom_range(0, 2);
    case (final_mode)
      0: begin
        // short patch written mid-hunk: the hunk carries on, next hunk start ends it
        push_skip($urandom_range(0, 127));
        repeat (3) push_xor(8'($urandom_range(1, 255)));
        wait_drained();
        set_patch_length($urandom_range(0, upsd_pkg::CHECKSUM_BYTES - 1));
        repeat (2) push_xor(8'($urandom_range(1, 255)));
        push_xor('0);
        repeat (upsd_pkg::CHECKSUM_BYTES + 4) push_byte(8'($urandom_range(0, 255)));
      end
      1: begin
        wait_drained();
        set_patch_length(gen_pos + upsd_pkg::CHECKSUM_BYTES + $urandom_range(0, 40));
        stop_pos = gen_pos + 80;
        while (gen_pos < stop_pos) push_random_hunk();
        repeat (upsd_pkg::CHECKSUM_BYTES) push_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        // run the offset up to its top; the last write still comes out
        push_skip(OFS_MAX - 64'd2 - gen_ofs);
        repeat (3) push_xor(8'($urandom_range(1, 255)));
        repeat (8) push_byte(8'($urandom_range(0, 255)));
      end
    endcase

    wait_drained();
    repeat (10) @(posedge clk);
    if (n_errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
